// ===== rtl/lpfr_pkg.sv =====
// Shared types and constants for the LCD page frame store refresh unit.
package lpfr_pkg;

  // Input request payload
  typedef struct packed {
    logic [1:0] mode;
    logic [6:0] pixel_x;
    logic [5:0] pixel_y;
  } in_item_t;

  // Result payload
  typedef struct packed {
    logic [15:0] spi_word;
    logic        is_data;
    logic [2:0]  page_index;
  } out_item_t;

  // Request modes
  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_PIXEL = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  // Register map (register index = byte address / 4)
  localparam logic [1:0] REG_ENABLE   = 2'd0;
  localparam logic [1:0] REG_GAP      = 2'd1;
  localparam logic [1:0] REG_COL_CMD  = 2'd2;
  localparam logic [1:0] REG_PAGE_CMD = 2'd3;

  // Register reset values
  localparam logic [15:0] GAP_TICKS_RST    = 16'd2000;
  localparam logic [15:0] COL_CMD_RST      = 16'h0210;
  localparam logic [15:0] PAGE_CMD_RST     = 16'h10B0;

  // Refresh cycle phase
  typedef enum logic [1:0] {
    PH_STREAM = 2'd0,
    PH_GAP1   = 2'd1,
    PH_GAP2   = 2'd2,
    PH_GAP3   = 2'd3
  } phase_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_RD_LO,
    ST_RD_HI,
    ST_EMIT,
    ST_PX_RD,
    ST_PX_WR
  } ctrl_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic latch_in;
    logic clr_step;
    logic rd_lo;
    logic rd_hi;
    logic px_rd;
    logic px_wr;
    logic load_out;
    logic tick_adv;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [1:0] mode;
    phase_t     phase;
    logic       enable;
    logic       gap_done;
    logic       clr_last;
    logic       out_free;
  } dp_stat_t;

endpackage

// ===== rtl/lpfr_ctrl.sv =====
// Sequencing state machine for the refresh unit: dispatch, memory access order, result hand-off.
module lpfr_ctrl
  import lpfr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  ctrl_state_t state_r, state_nxt;

  // State register; reset starts the frame store clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (stat.mode)
          MODE_TICK: begin
            if (!stat.enable) begin
              state_nxt = ST_IDLE;
            end else if (stat.phase == PH_STREAM) begin
              state_nxt = ST_RD_LO;
            end else if (stat.gap_done && stat.phase != PH_GAP3) begin
              state_nxt = ST_EMIT;
            end else begin
              cmd.tick_adv = 1'b1;
              state_nxt    = ST_IDLE;
            end
          end
          MODE_PIXEL: state_nxt = ST_PX_RD;
          MODE_CLEAR: state_nxt = ST_CLEAR;
          default:    state_nxt = ST_IDLE;
        endcase
      end
      ST_RD_LO: begin
        cmd.rd_lo = 1'b1;
        state_nxt = ST_RD_HI;
      end
      ST_RD_HI: begin
        cmd.rd_hi = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        // hold the finished word until the output register is free
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          cmd.tick_adv = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_PX_RD: begin
        cmd.px_rd = 1'b1;
        state_nxt = ST_PX_WR;
      end
      ST_PX_WR: begin
        cmd.px_wr = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/lpfr_dp.sv =====
// Datapath for the refresh unit: frame memory, refresh counters and the output register.
module lpfr_dp
  import lpfr_pkg::*;
#(
  parameter int PAGE_COUNT     = 8,
  parameter int PAGE_COLUMNS   = 132,
  parameter int WORDS_PER_PAGE = 66
) (
  input  logic        clk,
  input  logic        rst_n,
  input  in_item_t    in_data,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  input  logic        refresh_enable,
  input  logic        restart,
  input  logic [15:0] gap_ticks,
  input  logic [15:0] column_command,
  input  logic [15:0] page_command_base,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data
);

  localparam int STORE = PAGE_COUNT * PAGE_COLUMNS;
  localparam int AW    = $clog2(STORE);
  localparam int PG_HI = (PAGE_COUNT > 8) ? PAGE_COUNT : 8;
  localparam int EW    = $clog2(PG_HI * PAGE_COLUMNS + 2 * WORDS_PER_PAGE + 128);
  localparam int PW    = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int WW    = (WORDS_PER_PAGE > 1) ? $clog2(WORDS_PER_PAGE) : 1;

  logic [7:0]    frame_mem [STORE];
  logic [7:0]    rdata_r;
  logic [7:0]    lo_r;
  in_item_t      item_r;
  phase_t        phase_r;
  logic [PW-1:0] page_r;
  logic [WW-1:0] word_r;
  logic [15:0]   gap_r;
  logic [AW-1:0] clr_r;
  logic          out_valid_r;
  out_item_t     out_r;

  // Latch the accepted request
  always_ff @(posedge clk) begin
    if (cmd.latch_in) item_r <= in_data;
  end

  // Pixel mapping: mirror both axes, swap the column's lowest bit
  logic [6:0]    px_col;
  logic [5:0]    px_row;
  logic [EW-1:0] px_addr;
  assign px_col  = (~item_r.pixel_x) ^ 7'd1;
  assign px_row  = ~item_r.pixel_y;
  assign px_addr = EW'(px_row[5:3]) * EW'(PAGE_COLUMNS) + EW'(px_col);

  // Streaming byte address of the current word
  logic [EW-1:0] st_base;
  assign st_base = EW'(page_r) * EW'(PAGE_COLUMNS) + (EW'(word_r) << 1);

  // Read address select and range check
  logic [EW-1:0] rd_addr;
  logic          rd_en;
  logic          rd_ok;
  always_comb begin
    rd_addr = px_addr;
    if (cmd.rd_lo) rd_addr = st_base;
    if (cmd.rd_hi) rd_addr = st_base + EW'(1);
  end
  assign rd_en = cmd.rd_lo | cmd.rd_hi | cmd.px_rd;
  assign rd_ok = rd_addr < EW'(STORE);

  // Write select: clearing sweep or pixel OR
  logic          px_ok;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  assign px_ok   = px_addr < EW'(STORE);
  assign wr_en   = cmd.clr_step | (cmd.px_wr & px_ok);
  assign wr_addr = cmd.clr_step ? clr_r : px_addr[AW-1:0];
  assign wr_data = cmd.clr_step ? 8'd0 : (rdata_r | (8'd1 << px_row[2:0]));

  // Single-port frame memory with registered read
  always_ff @(posedge clk) begin
    if (wr_en) frame_mem[wr_addr] <= wr_data;
    if (rd_en) rdata_r <= rd_ok ? frame_mem[rd_addr[AW-1:0]] : 8'd0;
  end

  // Low byte of the streamed word
  always_ff @(posedge clk) begin
    if (cmd.rd_hi) lo_r <= rdata_r;
  end

  // Clearing sweep counter, wraps back to zero at the end
  logic clr_last;
  assign clr_last = (clr_r == AW'(STORE - 1));
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clr_step) begin
      clr_r <= clr_last ? '0 : clr_r + AW'(1);
    end
  end

  // Refresh cycle state
  logic          gap_done;
  logic          word_last;
  logic [PW-1:0] page_next;
  assign gap_done  = ({1'b0, gap_r} + 17'd1) >= {1'b0, gap_ticks};
  assign word_last = (word_r == WW'(WORDS_PER_PAGE - 1));
  assign page_next = (page_r == PW'(PAGE_COUNT - 1)) ? '0 : page_r + PW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      phase_r <= PH_STREAM;
      page_r  <= '0;
      word_r  <= '0;
      gap_r   <= '0;
    end else if (cmd.tick_adv) begin
      if (phase_r == PH_STREAM) begin
        if (word_last) begin
          word_r  <= '0;
          gap_r   <= '0;
          phase_r <= PH_GAP1;
        end else begin
          word_r <= word_r + WW'(1);
        end
      end else if (gap_done) begin
        gap_r <= '0;
        case (phase_r)
          PH_GAP1: begin
            page_r  <= page_next;
            phase_r <= PH_GAP2;
          end
          PH_GAP2: phase_r <= PH_GAP3;
          default: begin
            phase_r <= PH_STREAM;
            word_r  <= '0;
          end
        endcase
      end else begin
        gap_r <= gap_r + 16'd1;
      end
    end
  end

  // Result word for the current phase
  logic [PW+2:0] page_cur_x;
  logic [PW+2:0] page_nxt_x;
  out_item_t     res;
  assign page_cur_x = {3'b000, page_r};
  assign page_nxt_x = {3'b000, page_next};
  always_comb begin
    case (phase_r)
      PH_STREAM: res = '{spi_word: {rdata_r, lo_r}, is_data: 1'b1,
                         page_index: page_cur_x[2:0]};
      PH_GAP1:   res = '{spi_word: column_command, is_data: 1'b0,
                         page_index: page_nxt_x[2:0]};
      PH_GAP2:   res = '{spi_word: page_command_base | 16'(page_r), is_data: 1'b0,
                         page_index: page_cur_x[2:0]};
      default:   res = '0;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) out_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Status to the controller
  assign stat.mode     = item_r.mode;
  assign stat.phase    = phase_r;
  assign stat.enable   = refresh_enable;
  assign stat.gap_done = gap_done;
  assign stat.clr_last = clr_last;
  assign stat.out_free = ~out_valid_r | out_ready;

  // A result is only loaded into a free output register
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("result loaded over a pending result");

  // The single memory port never reads and writes in one cycle
  a_one_port: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.clr_step || cmd.px_wr) |-> !rd_en)
    else $error("frame memory read and write collide");

  // A pixel write follows directly on its read
  a_px_order: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.px_wr |-> $past(cmd.px_rd))
    else $error("pixel write without preceding read");

  // Page number stays inside the store
  a_page_range: assert property (@(posedge clk) disable iff (!rst_n)
    page_r <= PW'(PAGE_COUNT - 1))
    else $error("page index out of range");

endmodule

// ===== rtl/lcd_page_framebuffer_refresh_unit.sv =====
// Top level of the LCD page frame store refresh unit: register port and submodules.
//
// Usage: requests enter on in_valid/in_ready with in_data (mode, pixel_x,
// pixel_y). A tick request streams one 16-bit data word of the current page
// (odd column in the high byte) or, at the end of a gap, one command word;
// other ticks, set-pixel and clear requests give no result. Results leave on
// out_valid/out_ready with out_data (spi_word, is_data, page_index).
// Registers sit on the APB-style port at byte addresses 0, 4, 8 and 12;
// pready is always high. Write them only while the unit is idle.
// Steps per request, from acceptance to the next in_ready: a streaming
// tick dispatches, makes two reads of the single-port byte memory and
// emits; a tick that ends the first or second gap dispatches and emits;
// any other tick and an unused mode only dispatch; a set-pixel dispatches,
// then reads and writes back its byte (read-modify-write on the same
// port); a clear dispatches, then sweeps the whole store. A result is
// loaded into the output register on emit, once that register is free.
// After reset the unit sweeps the memory to zero with in_ready low;
// register writes are taken during the sweep.
// A stalled receiver holds the result in the output register; the unit
// keeps taking requests and waits only when a new result is ready to load.
module lcd_page_framebuffer_refresh_unit
  import lpfr_pkg::*;
#(
  parameter int PAGE_COUNT     = 8,
  parameter int PAGE_COLUMNS   = 132,
  parameter int WORDS_PER_PAGE = 66
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic        enable_r;
  logic [15:0] gap_ticks_r;
  logic [15:0] col_cmd_r;
  logic [15:0] page_cmd_r;
  logic        cfg_wr;
  logic [1:0]  reg_idx;
  logic        restart;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];
  assign restart = cfg_wr && (reg_idx == REG_ENABLE) && !pwdata[0];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r    <= 1'b0;
      gap_ticks_r <= GAP_TICKS_RST;
      col_cmd_r   <= COL_CMD_RST;
      page_cmd_r  <= PAGE_CMD_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_ENABLE:   enable_r    <= pwdata[0];
        REG_GAP:      gap_ticks_r <= pwdata[15:0];
        REG_COL_CMD:  col_cmd_r   <= pwdata[15:0];
        REG_PAGE_CMD: page_cmd_r  <= pwdata[15:0];
        default:      ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (reg_idx)
      REG_ENABLE:   prdata = {31'd0, enable_r};
      REG_GAP:      prdata = {16'd0, gap_ticks_r};
      REG_COL_CMD:  prdata = {16'd0, col_cmd_r};
      REG_PAGE_CMD: prdata = {16'd0, page_cmd_r};
      default:      prdata = '0;
    endcase
  end

  dp_cmd_t  cmd;
  dp_stat_t stat;

  lpfr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lpfr_dp #(
    .PAGE_COUNT     (PAGE_COUNT),
    .PAGE_COLUMNS   (PAGE_COLUMNS),
    .WORDS_PER_PAGE (WORDS_PER_PAGE)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_data           (in_data),
    .cmd               (cmd),
    .stat              (stat),
    .refresh_enable    (enable_r),
    .restart           (restart),
    .gap_ticks         (gap_ticks_r),
    .column_command    (col_cmd_r),
    .page_command_base (page_cmd_r),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_data          (out_data)
  );

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the LCD page frame store refresh unit.
`timescale 1ns / 100ps

module testbench;
  import lpfr_pkg::*;

  localparam int PAGES         = 8;
  localparam int COLS          = 132;
  localparam int WORDS         = 66;
  localparam int IDLE_PCT      = 23;
  localparam int SETTLE_CYCLES = 1200;    // covers a full clear walk
  localparam int HOLD_AT       = 60;      // results seen before the long hold-off
  localparam int HOLD_LEN      = 300;
  localparam int CYCLE_LIMIT   = 500000;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  lcd_page_framebuffer_refresh_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // Shadow copy of the frame store, refresh state and registers
  logic [7:0]  frame_bytes [0:PAGES*COLS-1];
  phase_t      m_phase;
  int          m_page;
  int          m_word_cnt;
  int          m_gap_cnt;
  logic        m_enable;
  int          m_gap_ticks;
  logic [15:0] m_col_cmd;
  logic [15:0] m_page_cmd;

  in_item_t    req_fifo [$];        // requests waiting to be driven
  out_item_t   pending_words [$];   // display words still to arrive
  int          queued_total = 0;
  int          acc_total = 0;
  int          err_cnt = 0;
  int          cycle_cnt = 0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic report_mismatch(string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  function automatic void restart_refresh();
    m_phase    = PH_STREAM;
    m_page     = 0;
    m_word_cnt = 0;
    m_gap_cnt  = 0;
  endfunction

  // One tick of a gap; true on the tick that closes it (zero length acts as one)
  function automatic bit gap_end();
    if (m_gap_cnt + 1 >= m_gap_ticks) begin
      m_gap_cnt = 0;
      return 1'b1;
    end
    m_gap_cnt = m_gap_cnt + 1;
    return 1'b0;
  endfunction

  // Advance the shadow state by one request; returns 1 when a display word results
  function automatic bit refresh_step(input in_item_t req, output out_item_t word);
    int base;
    int col;
    int row;
    word = '0;
    refresh_step = 1'b0;
    if (req.mode == MODE_PIXEL) begin
      // mirror both axes, swap the column's low bit
      col = (127 - int'(req.pixel_x)) ^ 1;
      row = 63 - int'(req.pixel_y);
      frame_bytes[(row >> 3) * COLS + col] |= 8'(1 << (row & 7));
    end else if (req.mode == MODE_CLEAR) begin
      foreach (frame_bytes[i]) frame_bytes[i] = '0;
    end else if (req.mode == MODE_TICK && m_enable) begin
      case (m_phase)
        PH_STREAM: begin
          base = m_page * COLS + 2 * m_word_cnt;
          word.spi_word   = {frame_bytes[base + 1], frame_bytes[base]};
          word.is_data    = 1'b1;
          word.page_index = 3'(m_page);
          refresh_step = 1'b1;
          m_word_cnt++;
          if (m_word_cnt >= WORDS) begin
            m_word_cnt = 0;
            m_gap_cnt  = 0;
            m_phase    = PH_GAP1;
          end
        end
        PH_GAP1: if (gap_end()) begin
          // page advances before the column command goes out
          m_page  = (m_page + 1) % PAGES;
          m_phase = PH_GAP2;
          word.spi_word   = m_col_cmd;
          word.page_index = 3'(m_page);
          refresh_step = 1'b1;
        end
        PH_GAP2: if (gap_end()) begin
          m_phase = PH_GAP3;
          word.spi_word   = m_page_cmd | 16'(m_page);
          word.page_index = 3'(m_page);
          refresh_step = 1'b1;
        end
        default: if (gap_end()) begin
          m_phase    = PH_STREAM;
          m_word_cnt = 0;
        end
      endcase
    end
  endfunction

  // Register write: setup cycle, access cycle, then update the shadow registers
  task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_ENABLE: begin
        if (!val[0]) restart_refresh();
        m_enable = val[0];
      end
      REG_GAP:      m_gap_ticks = int'(val[15:0]);
      REG_COL_CMD:  m_col_cmd   = val[15:0];
      REG_PAGE_CMD: m_page_cmd  = val[15:0];
      default: ;
    endcase
  endtask

  task automatic queue_req(logic [1:0] mode, logic [6:0] x, logic [5:0] y);
    in_item_t r;
    r.mode    = mode;
    r.pixel_x = x;
    r.pixel_y = y;
    req_fifo.push_back(r);
    queued_total++;
  endtask

  // Mostly ticks and pixels; clears and the unused mode now and then
  task automatic queue_random(int n, int tick_pct);
    int pick;
    logic [1:0] mode;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < tick_pct) mode = MODE_TICK;
      else if (pick < 95) mode = MODE_PIXEL;
      else if (pick < 97) mode = MODE_CLEAR;
      else mode = MODE_UNUSED;
      queue_req(mode, 7'($urandom_range(127)), 6'($urandom_range(63)));
    end
  endtask

  // Sender holds off until every request is taken and every word has arrived
  task automatic settle();
    while (!(acc_total == queued_total && pending_words.size() == 0)) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Request driver
  always @(posedge clk) begin : drive
    out_item_t w;
    bit        has;
    int        idle;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        has = refresh_step(in_data, w);
        if (has) pending_words.push_back(w);
        acc_total++;
      end
      idle = (acc_total >= 250 && acc_total < 400) ? 0 : IDLE_PCT;
      if (!in_valid || in_ready) begin
        if (req_fifo.size() > 0 && $urandom_range(99) >= idle) begin
          in_data  <= req_fifo.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random stalls and one long hold-off
  always @(posedge clk) begin : monitor
    out_item_t w;
    int        res_seen;
    int        hold_left;
    bit        hold_done;
    int        idle;
    if (!rst_n) begin
      out_ready <= 1'b0;
      res_seen  = 0;
      hold_left = 0;
      hold_done = 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        res_seen++;
        if (pending_words.size() == 0) begin
          report_mismatch($sformatf("unexpected word %h data=%b page=%0d",
                                    out_data.spi_word, out_data.is_data,
                                    out_data.page_index));
        end else begin
          w = pending_words.pop_front();
          if (out_data.spi_word !== w.spi_word)
            report_mismatch($sformatf("spi_word %h, want %h", out_data.spi_word,
                                      w.spi_word));
          if (out_data.is_data !== w.is_data)
            report_mismatch($sformatf("is_data %b, want %b", out_data.is_data,
                                      w.is_data));
          if (out_data.page_index !== w.page_index)
            report_mismatch($sformatf("page_index %0d, want %0d",
                                      out_data.page_index, w.page_index));
        end
      end
      idle = (res_seen >= 200 && res_seen < 300) ? 0 : IDLE_PCT;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (res_seen == HOLD_AT && !hold_done) begin
        hold_left = HOLD_LEN;
        hold_done = 1'b1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= idle);
      end
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Stimulus sequence
  initial begin
    foreach (frame_bytes[i]) frame_bytes[i] = '0;
    restart_refresh();
    m_enable    = 1'b0;
    m_gap_ticks = int'(GAP_TICKS_RST);
    m_col_cmd   = COL_CMD_RST;
    m_page_cmd  = PAGE_CMD_RST;

    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Refresh stopped: ticks give nothing, pixels at the corners, unused mode
    cfg_write(REG_ENABLE, 32'd0);
    cfg_write(REG_GAP, 32'd1);
    cfg_write(REG_COL_CMD, 32'hFFFF);
    cfg_write(REG_PAGE_CMD, 32'h0000);
    queue_req(MODE_TICK, 7'd0, 6'd0);
    queue_req(MODE_PIXEL, 7'd0, 6'd0);
    queue_req(MODE_PIXEL, 7'd127, 6'd63);
    queue_req(MODE_PIXEL, 7'd127, 6'd0);
    queue_req(MODE_PIXEL, 7'd0, 6'd63);
    queue_req(MODE_PIXEL, 7'd1, 6'd1);
    queue_req(MODE_PIXEL, 7'd126, 6'd62);
    queue_req(MODE_PIXEL, 7'd64, 6'd7);
    queue_req(MODE_UNUSED, 7'd127, 6'd63);
    queue_req(MODE_TICK, 7'd127, 6'd63);
    settle();

    // Refresh on: first words of page zero, then a clear mid-page
    cfg_write(REG_ENABLE, 32'd1);
    queue_req(MODE_TICK, 7'd0, 6'd0);
    queue_req(MODE_TICK, 7'd0, 6'd0);
    queue_req(MODE_TICK, 7'd0, 6'd0);
    queue_req(MODE_CLEAR, 7'd127, 6'd63);
    queue_req(MODE_TICK, 7'd0, 6'd0);
    queue_req(MODE_PIXEL, 7'd63, 6'd32);
    queue_req(MODE_TICK, 7'd0, 6'd0);
    settle();

    // Shortest gaps; enabling again while enabled must change nothing
    cfg_write(REG_ENABLE, 32'd1);
    queue_random(110, 70);
    settle();

    // Restart from page zero, zero-length gaps, extreme command words
    cfg_write(REG_ENABLE, 32'd0);
    cfg_write(REG_GAP, 32'd0);
    cfg_write(REG_COL_CMD, 32'h0000);
    cfg_write(REG_PAGE_CMD, 32'hFFFF);
    cfg_write(REG_ENABLE, 32'd1);
    queue_random(100, 70);
    settle();

    // Longest gap: one page of words, then stuck inside the first gap
    cfg_write(REG_ENABLE, 32'd0);
    cfg_write(REG_GAP, 32'd65535);
    cfg_write(REG_ENABLE, 32'd1);
    queue_random(80, 100);
    settle();

    // Gap shortened while inside it: it closes on the next tick
    cfg_write(REG_GAP, 32'd3);
    cfg_write(REG_COL_CMD, 32'($urandom_range(65535)));
    cfg_write(REG_PAGE_CMD, 32'($urandom_range(65535)));
    queue_random(120, 75);
    settle();

    // Back to the reset command words
    cfg_write(REG_GAP, 32'($urandom_range(1, 6)));
    cfg_write(REG_COL_CMD, 32'(COL_CMD_RST));
    cfg_write(REG_PAGE_CMD, 32'(PAGE_CMD_RST));
    queue_random(75, 70);
    settle();

    // Random settings, sometimes restarting the refresh
    for (int p = 0; p < 3; p++) begin
      if ($urandom_range(1)) cfg_write(REG_ENABLE, 32'd0);
      cfg_write(REG_ENABLE, 32'd1);
      cfg_write(REG_GAP, 32'($urandom_range(1, 8)));
      cfg_write(REG_COL_CMD, 32'($urandom_range(65535)));
      cfg_write(REG_PAGE_CMD, 32'($urandom_range(65535)));
      queue_random(50, 70);
      settle();
    end

    if (pending_words.size() != 0)
      report_mismatch($sformatf("%0d display words never arrived", pending_words.size()));
    if (err_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== lcd_page_framebuffer_refresh_unit.f =====
rtl/lpfr_pkg.sv
rtl/lpfr_ctrl.sv
rtl/lpfr_dp.sv
rtl/lcd_page_framebuffer_refresh_unit.sv
tb/testbench.sv
